@@ sv/delta_timer_task_queue_core_defines.svh @@
// Assertion macros of the timer queue RTL.
// Included by files that carry concurrent assertions; depends on nothing.
`ifndef DELTA_TIMER_TASK_QUEUE_CORE_DEFINES_SVH
`define DELTA_TIMER_TASK_QUEUE_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define DTQ_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("timer queue assertion failed");

// Next-cycle implication, disabled during reset.
`define DTQ_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("timer queue assertion failed");

`endif

@@ sv/dtq_pkg.sv @@
// Shared types and constants of the delta timer task queue.
// Used by dtq_cell and delta_timer_task_queue_core; depends on nothing.
`timescale 1ns / 1ps

package dtq_pkg;

  localparam int QUEUE_DEPTH = 8;
  localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int HANDLE_W    = 8;
  localparam int DATA_W      = 32;

  typedef logic [1:0] op_t;
  localparam op_t OP_TICK     = 2'd0;
  localparam op_t OP_ADD      = 2'd1;
  localparam op_t OP_DELETE   = 2'd2;
  localparam op_t OP_DISPATCH = 2'd3;

  // Per-cell command codes.
  typedef logic [2:0] cell_mode_t;
  localparam cell_mode_t MODE_HOLD       = 3'd0;
  localparam cell_mode_t MODE_TICK       = 3'd1;
  localparam cell_mode_t MODE_PREV       = 3'd2;
  localparam cell_mode_t MODE_PREV_SPLIT = 3'd3;
  localparam cell_mode_t MODE_LOAD       = 3'd4;
  localparam cell_mode_t MODE_NEXT       = 3'd5;
  localparam cell_mode_t MODE_NEXT_MERGE = 3'd6;

  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic [DATA_W-1:0]   delta;
    logic [DATA_W-1:0]   period;
    logic                ready;
    logic [DATA_W-1:0]   id;
  } entry_t;

endpackage

@@ sv/dtq_cell.sv @@
// One slot of the delta-sorted timer queue.
// Depends on dtq_pkg for entry_t and the cell command codes.
`timescale 1ns / 1ps

module dtq_cell import dtq_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  cell_mode_t          mode,
  input  entry_t              prev,
  input  entry_t              next,
  input  entry_t              load,
  input  logic [DATA_W-1:0]   split,
  output entry_t              q
);

  entry_t            q_next;
  logic [DATA_W-1:0] dec;

  always_comb begin
    q_next = q;
    dec    = (q.delta != '0) ? (q.delta - DATA_W'(1)) : q.delta;
    case (mode)
      MODE_TICK: begin
        // count down only a live entry that is not yet due
        if (q.handle != '0 && !q.ready) begin
          q_next.delta = dec;
          q_next.ready = (dec == '0);
        end
      end
      MODE_PREV: q_next = prev;
      MODE_PREV_SPLIT: begin
        q_next       = prev;
        q_next.delta = split;
      end
      MODE_LOAD: q_next = load;
      MODE_NEXT: q_next = next;
      MODE_NEXT_MERGE: begin
        // hand the leaving entry's delta to its successor, if any
        q_next = next;
        if (next.handle != '0) begin
          q_next.delta = next.delta + q.delta;
        end
      end
      default: q_next = q;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q <= '0;
    end else begin
      q <= q_next;
    end
  end

endmodule

@@ sv/delta_timer_task_queue_core.sv @@
// Top level of the delta timer task queue: sequencer plus row of slot cells.
// Depends on dtq_pkg, dtq_cell and delta_timer_task_queue_core_defines.svh.
`timescale 1ns / 1ps
`include "delta_timer_task_queue_core_defines.svh"

// Delta-list timer queue. A request is taken on a rising edge with start high
// and busy low; exactly one result follows, shown for one cycle with done high
// and it cannot be held off, so capture it when done is seen. Tick, dispatch of a
// one-shot head and a dispatch that does not fire are answered straight from the
// idle state. Add walks the running sum one slot per cycle through a single
// adder and compare until it reaches the slot it lands in or the tail, then the
// insert state shifts the row and loads the new entry. Delete compares one id per
// cycle until it finds the matching id, reaches the fill level or has checked the
// last slot. A firing periodic dispatch pops the head in the cycle it is taken
// and then runs the add walk for the re-insert. done rises in the cycle after the
// last state of a request, and a new request may be taken in that same cycle.
// Refused adds (handle zero or full queue) and deletes of id zero are also
// answered straight from the idle state.
module delta_timer_task_queue_core import dtq_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          op,
  input  logic [HANDLE_W-1:0] task_handle,
  input  logic [DATA_W-1:0]   start_delay,
  input  logic [DATA_W-1:0]   repeat_period,
  input  logic [DATA_W-1:0]   target_id,
  output logic                done,
  output logic [DATA_W-1:0]   result_id,
  output logic                success,
  output logic [HANDLE_W-1:0] run_handle
);

  // Sequencer states
  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_WALK   = 2'd1;
  localparam logic [1:0] S_INSERT = 2'd2;
  localparam logic [1:0] S_SEARCH = 2'd3;

  localparam logic [IDX_W-1:0]       IDX_LAST = IDX_W'(QUEUE_DEPTH - 1);
  localparam logic [QUEUE_DEPTH-1:0] OCC_ONE  = QUEUE_DEPTH'(1);

  // Slot row
  entry_t     cells_q   [QUEUE_DEPTH];
  cell_mode_t cell_mode [QUEUE_DEPTH];
  entry_t     load_entry;

  logic [QUEUE_DEPTH-1:0] occ;
  logic [QUEUE_DEPTH-1:0] occ_inc;

  // Sequencer registers
  logic [1:0]          state, state_next;
  logic [IDX_W-1:0]    idx, idx_next;
  logic [DATA_W:0]     sum, sum_next;          // running sum before slot idx
  logic                found, found_next;
  logic [DATA_W-1:0]   split, split_next;      // delta left to the displaced slot
  logic [HANDLE_W-1:0] add_handle, add_handle_next;
  logic [DATA_W-1:0]   add_delay, add_delay_next;
  logic [DATA_W-1:0]   add_period, add_period_next;
  logic [DATA_W-1:0]   target, target_next;
  logic                is_dispatch, is_dispatch_next;
  logic [DATA_W-1:0]   last_id, last_id_next;

  // Result registers
  logic                done_next;
  logic [DATA_W-1:0]   result_id_next;
  logic                success_next;
  logic [HANDLE_W-1:0] run_handle_next;

  // Datapath helpers
  entry_t            cur;
  logic [DATA_W:0]   s_walk;
  logic [DATA_W-1:0] new_id;
  logic [DATA_W-1:0] nd;
  logic [IDX_W:0]    idx_plus;
  logic              accept;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      occ[i] = (cells_q[i].handle != '0);
    end
  end
  assign occ_inc = occ + OCC_ONE;

  // Walk tap: one slot per cycle through one adder and one compare
  assign cur      = cells_q[idx];
  assign s_walk   = sum + {1'b0, cur.delta};
  assign idx_plus = {1'b0, idx} + (IDX_W + 1)'(1);

  // Fresh id: advance and skip zero
  assign new_id = ((last_id + DATA_W'(1)) == '0) ? DATA_W'(1) : (last_id + DATA_W'(1));

  // New entry's delta is its delay minus everything ahead of it
  assign nd = add_delay - sum[DATA_W-1:0];

  always_comb begin
    load_entry.handle = add_handle;
    load_entry.delta  = nd;
    load_entry.period = add_period;
    load_entry.ready  = (nd == '0);
    load_entry.id     = new_id;
  end

  always_comb begin
    state_next       = state;
    idx_next         = idx;
    sum_next         = sum;
    found_next       = found;
    split_next       = split;
    add_handle_next  = add_handle;
    add_delay_next   = add_delay;
    add_period_next  = add_period;
    target_next      = target;
    is_dispatch_next = is_dispatch;
    last_id_next     = last_id;
    done_next        = 1'b0;
    result_id_next   = result_id;
    success_next     = success;
    run_handle_next  = run_handle;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      cell_mode[i] = MODE_HOLD;
    end

    case (state)
      S_IDLE: begin
        if (accept) begin
          // default answer: nothing done
          result_id_next  = '0;
          success_next    = 1'b0;
          run_handle_next = '0;
          case (op)
            OP_TICK: begin
              // only the head counts down
              cell_mode[0] = MODE_TICK;
              done_next    = 1'b1;
            end
            OP_ADD: begin
              if (task_handle == '0 || occ[QUEUE_DEPTH-1]) begin
                done_next = 1'b1;              // refuse: no handle or no room
              end else begin
                add_handle_next  = task_handle;
                add_delay_next   = start_delay;
                add_period_next  = repeat_period;
                is_dispatch_next = 1'b0;
                sum_next         = '0;
                idx_next         = '0;
                state_next       = S_WALK;
              end
            end
            OP_DELETE: begin
              if (target_id == '0) begin
                done_next = 1'b1;
              end else begin
                target_next = target_id;
                idx_next    = '0;
                state_next  = S_SEARCH;
              end
            end
            OP_DISPATCH: begin
              if (occ[0] && cells_q[0].ready) begin
                // pop the head; the row moves up one slot
                for (int i = 0; i < QUEUE_DEPTH; i++) begin
                  cell_mode[i] = (i == 0) ? MODE_NEXT_MERGE : MODE_NEXT;
                end
                run_handle_next = cells_q[0].handle;
                success_next    = 1'b1;
                if (cells_q[0].period != '0) begin
                  // re-arm with its own period
                  add_handle_next  = cells_q[0].handle;
                  add_delay_next   = cells_q[0].period;
                  add_period_next  = cells_q[0].period;
                  is_dispatch_next = 1'b1;
                  sum_next         = '0;
                  idx_next         = '0;
                  state_next       = S_WALK;
                end else begin
                  done_next = 1'b1;
                end
              end else begin
                done_next = 1'b1;
              end
            end
            default: done_next = 1'b1;
          endcase
        end
      end

      S_WALK: begin
        if (!occ[idx]) begin
          // reached the tail: append
          found_next = 1'b0;
          state_next = S_INSERT;
        end else if (s_walk > {1'b0, add_delay}) begin
          // go in front of this slot and split its delta
          found_next = 1'b1;
          split_next = s_walk[DATA_W-1:0] - add_delay;
          state_next = S_INSERT;
        end else begin
          sum_next = s_walk;
          idx_next = idx_plus[IDX_W-1:0];
        end
      end

      S_INSERT: begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
          if (IDX_W'(i) == idx) begin
            cell_mode[i] = MODE_LOAD;
          end else if (found && (IDX_W + 1)'(i) == idx_plus) begin
            cell_mode[i] = MODE_PREV_SPLIT;
          end else if (found && IDX_W'(i) > idx) begin
            cell_mode[i] = MODE_PREV;
          end
        end
        last_id_next    = new_id;
        result_id_next  = is_dispatch ? '0 : new_id;
        success_next    = 1'b1;
        run_handle_next = is_dispatch ? add_handle : '0;
        done_next       = 1'b1;
        state_next      = S_IDLE;
      end

      S_SEARCH: begin
        if (!occ[idx]) begin
          done_next  = 1'b1;                   // id not in the queue
          state_next = S_IDLE;
        end else if (cur.id == target) begin
          // drop this slot; its successor inherits the delta
          for (int i = 0; i < QUEUE_DEPTH; i++) begin
            if (IDX_W'(i) == idx) begin
              cell_mode[i] = MODE_NEXT_MERGE;
            end else if (IDX_W'(i) > idx) begin
              cell_mode[i] = MODE_NEXT;
            end
          end
          success_next = 1'b1;
          done_next    = 1'b1;
          state_next   = S_IDLE;
        end else if (idx == IDX_LAST) begin
          done_next  = 1'b1;
          state_next = S_IDLE;
        end else begin
          idx_next = idx_plus[IDX_W-1:0];
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      done    <= 1'b0;
      last_id <= '0;
    end else begin
      state   <= state_next;
      done    <= done_next;
      last_id <= last_id_next;
    end
  end

  always_ff @(posedge clk) begin
    idx         <= idx_next;
    sum         <= sum_next;
    found       <= found_next;
    split       <= split_next;
    add_handle  <= add_handle_next;
    add_delay   <= add_delay_next;
    add_period  <= add_period_next;
    target      <= target_next;
    is_dispatch <= is_dispatch_next;
    result_id   <= result_id_next;
    success     <= success_next;
    run_handle  <= run_handle_next;
  end

  // Row of slot cells; each one sees only its two neighbors
  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    entry_t prev_e;
    entry_t next_e;
    if (g == 0) begin : g_first
      assign prev_e = '0;
    end else begin : g_mid_prev
      assign prev_e = cells_q[g-1];
    end
    if (g == QUEUE_DEPTH - 1) begin : g_last
      assign next_e = '0;
    end else begin : g_mid_next
      assign next_e = cells_q[g+1];
    end
    dtq_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .mode  (cell_mode[g]),
      .prev  (prev_e),
      .next  (next_e),
      .load  (load_entry),
      .split (split),
      .q     (cells_q[g])
    );
  end

  // Live slots always form an unbroken run from slot 0
  `DTQ_ASSERT_IMP(a_occ_contig, clk, rst, 1'b1, (occ_inc & occ) == '0)
  // An insert walk only runs with at least one free slot
  `DTQ_ASSERT_IMP(a_walk_room, clk, rst, state == S_WALK, !occ[QUEUE_DEPTH-1])
  // Every taken request is either still in work or answered next cycle
  `DTQ_ASSERT_NXT(a_req_answer, clk, rst, accept, busy || done)
  // A nonzero id is only reported for a successful add, never mid-operation
  `DTQ_ASSERT_IMP(a_id_ok, clk, rst, done && result_id != '0, success && !busy)

endmodule

@@ tb/sv/delta_timer_task_queue_core_test.sv @@
// Self-checking testbench of delta_timer_task_queue_core: directed and random requests
// against an in-bench model of the delta-list timer queue. Depends on dtq_pkg and the RTL.
`timescale 1ns / 1ps

module delta_timer_task_queue_core_test;
  import dtq_pkg::*;

  localparam int RANDOM_COUNT = 1800;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int TAIL_CYCLES  = 40;
  localparam logic [DATA_W-1:0] ALL_ONES = {DATA_W{1'b1}};

  // One request as queued for the driver. A live target is resolved, when the queue
  // is not empty, to the id of a slot that is occupied at the moment the request goes out.
  typedef struct {
    op_t                 op;
    logic [HANDLE_W-1:0] handle;
    logic [DATA_W-1:0]   delay;
    logic [DATA_W-1:0]   period;
    logic [DATA_W-1:0]   target;
    bit                  live_target;
    bit                  drain_first;
    int                  idle_pct;
  } request_t;

  typedef struct packed {
    logic [DATA_W-1:0]   rid;
    logic                ok;
    logic [HANDLE_W-1:0] run;
  } outcome_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  logic                busy;
  op_t                 op = OP_TICK;
  logic [HANDLE_W-1:0] task_handle = '0;
  logic [DATA_W-1:0]   start_delay = '0;
  logic [DATA_W-1:0]   repeat_period = '0;
  logic [DATA_W-1:0]   target_id = '0;
  logic                done;
  logic [DATA_W-1:0]   result_id;
  logic                success;
  logic [HANDLE_W-1:0] run_handle;

  request_t request_backlog[$];
  outcome_t due_outcomes[$];
  request_t in_flight;
  int       mismatches = 0;
  int       cycles = 0;

  // Shadow copy of the queue: slot rows plus the id counter.
  entry_t            slots[QUEUE_DEPTH];
  logic [DATA_W-1:0] last_id = '0;

  delta_timer_task_queue_core i_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .op           (op),
    .task_handle  (task_handle),
    .start_delay  (start_delay),
    .repeat_period(repeat_period),
    .target_id    (target_id),
    .done         (done),
    .result_id    (result_id),
    .success      (success),
    .run_handle   (run_handle)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Queue model
  // ---------------------------------------------------------------------------

  // Count occupied slots; they always form an unbroken run from slot 0.
  function automatic int fill_level();
    int n;
    n = 0;
    while (n < QUEUE_DEPTH && slots[n].handle != '0) n++;
    return n;
  endfunction

  // Issue the next id, skipping zero on wrap.
  function automatic logic [DATA_W-1:0] issue_id();
    last_id = last_id + 1'b1;
    if (last_id == '0) last_id = DATA_W'(1);
    return last_id;
  endfunction

  // Insert ahead of the first entry whose running sum exceeds the delay, so equal
  // expiry times keep their arrival order. Return the new id, or zero if refused.
  function automatic logic [DATA_W-1:0] insert_task(logic [HANDLE_W-1:0] handle,
                                                    logic [DATA_W-1:0] delay,
                                                    logic [DATA_W-1:0] period);
    int          n;
    int          pos;
    int          k;
    logic [63:0] sum;
    logic [63:0] ahead;
    logic [DATA_W-1:0] nd;
    n = fill_level();
    pos = n;
    sum = '0;
    if (handle == '0 || n >= QUEUE_DEPTH) return '0;
    for (k = 0; k < n; k++) begin
      sum = sum + 64'(slots[k].delta);
      if (sum > 64'(delay)) begin
        pos = k;
        break;
      end
    end
    if (pos < n) begin
      // Split the delta of the entry we land in front of, then open the slot.
      ahead = sum - 64'(slots[pos].delta);
      nd = DATA_W'(64'(delay) - ahead);
      slots[pos].delta = DATA_W'(sum - 64'(delay));
      for (k = n; k > pos; k--) slots[k] = slots[k-1];
    end else begin
      nd = DATA_W'(64'(delay) - sum);
    end
    slots[pos].handle = handle;
    slots[pos].delta  = nd;
    slots[pos].period = period;
    slots[pos].ready  = (nd == '0);
    slots[pos].id     = issue_id();
    return slots[pos].id;
  endfunction

  // Drop one slot: hand its delta to the follower, move the tail up, clear the end.
  function automatic void remove_slot(int idx);
    int k;
    if (idx + 1 < QUEUE_DEPTH && slots[idx+1].handle != '0)
      slots[idx+1].delta = slots[idx+1].delta + slots[idx].delta;
    for (k = idx; k + 1 < QUEUE_DEPTH; k++) slots[k] = slots[k+1];
    slots[QUEUE_DEPTH-1] = '0;
  endfunction

  // Advance the model by one request and return the result it must produce.
  function automatic outcome_t timer_queue_step(request_t r);
    outcome_t            o;
    int                  n;
    int                  k;
    logic [HANDLE_W-1:0] h;
    logic [DATA_W-1:0]   p;
    o = '0;
    n = fill_level();
    case (r.op)
      OP_TICK: begin
        // Count down the head only; a ready head stays as it is.
        if (n > 0 && !slots[0].ready) begin
          if (slots[0].delta != '0) slots[0].delta = slots[0].delta - 1'b1;
          if (slots[0].delta == '0) slots[0].ready = 1'b1;
        end
      end
      OP_ADD: begin
        o.rid = insert_task(r.handle, r.delay, r.period);
        o.ok  = (o.rid != '0);
      end
      OP_DELETE: begin
        if (r.target != '0) begin
          for (k = 0; k < n; k++) begin
            if (slots[k].id == r.target) begin
              remove_slot(k);
              o.ok = 1'b1;
              break;
            end
          end
        end
      end
      OP_DISPATCH: begin
        // Pop a ready head; re-arm periodic tasks with a fresh id.
        if (n > 0 && slots[0].ready) begin
          h = slots[0].handle;
          p = slots[0].period;
          o.run = h;
          o.ok  = 1'b1;
          remove_slot(0);
          if (p != '0) void'(insert_task(h, p, p));
        end
      end
      default: ;
    endcase
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  task automatic queue_request(op_t o, logic [HANDLE_W-1:0] h, logic [DATA_W-1:0] d,
                               logic [DATA_W-1:0] p, logic [DATA_W-1:0] t);
    request_t r;
    r.op          = o;
    r.handle      = h;
    r.delay       = d;
    r.period      = p;
    r.target      = t;
    r.live_target = 1'b0;
    r.drain_first = 1'b0;
    r.idle_pct    = 12;
    request_backlog.push_back(r);
  endtask

  // Mostly well-formed traffic: small delays and periods so tasks expire and
  // re-arm, deletes aimed at live ids, and a sprinkling of odd values.
  function automatic request_t random_request(int idle_pct);
    request_t r;
    int       pick;
    pick = $urandom_range(99);
    r.op = (pick < 35) ? OP_TICK : (pick < 62) ? OP_ADD : (pick < 77) ? OP_DELETE : OP_DISPATCH;
    r.handle = ($urandom_range(99) < 5) ? '0 : HANDLE_W'($urandom_range(255, 1));
    pick = $urandom_range(99);
    if (pick < 70)      r.delay = $urandom_range(15);
    else if (pick < 85) r.delay = $urandom_range(300, 16);
    else if (pick < 95) r.delay = $urandom;
    else                r.delay = $urandom_range(1) ? ALL_ONES : '0;
    pick = $urandom_range(99);
    if (pick < 45)      r.period = '0;
    else if (pick < 85) r.period = $urandom_range(12, 1);
    else if (pick < 95) r.period = $urandom;
    else                r.period = ALL_ONES;
    pick = $urandom_range(99);
    r.live_target = (pick < 80);
    if (pick < 90)      r.target = $urandom;
    else if (pick < 95) r.target = '0;
    else                r.target = $urandom_range(64, 1);
    r.drain_first = 1'b0;
    r.idle_pct    = idle_pct;
    return r;
  endfunction

  task automatic log_mismatch(string msg);
    mismatches++;
    if (mismatches <= 10) $display("%s", msg);
  endtask

  initial begin
    request_t r;
    int       k;
    int       idle;
    // Directed opening: empty-queue corner cases first.
    queue_request(OP_TICK,     '0,    '0,       '0,       '0);
    queue_request(OP_DISPATCH, '0,    '0,       '0,       '0);
    queue_request(OP_DELETE,   '0,    '0,       '0,       '0);
    queue_request(OP_DELETE,   '0,    '0,       '0,       ALL_ONES);
    queue_request(OP_ADD,      '0,    3,        0,        '0);       // handle zero: refused
    queue_request(OP_ADD,      8'hFF, '0,       '0,       '0);       // zero delay: ready at once
    queue_request(OP_DISPATCH, '0,    '0,       '0,       '0);       // one-shot fires
    queue_request(OP_ADD,      8'h01, ALL_ONES, ALL_ONES, '0);
    queue_request(OP_ADD,      8'h02, 5,        3,        '0);       // splits the long delta
    queue_request(OP_ADD,      8'h03, 5,        0,        '0);       // tie keeps arrival order
    queue_request(OP_ADD,      8'h80, 2,        0,        '0);       // new head
    queue_request(OP_TICK,     '0,    '0,       '0,       '0);
    queue_request(OP_TICK,     '0,    '0,       '0,       '0);
    queue_request(OP_DISPATCH, '0,    '0,       '0,       '0);
    queue_request(OP_DELETE,   '0,    '0,       '0,       4);        // middle entry
    // Fill to the last slot, then one more add that must be refused.
    for (k = 0; k < 7; k++) queue_request(OP_ADD, HANDLE_W'(8'h40 + k), 6 + k, '0, '0);
    queue_request(OP_DELETE,   '0,    '0,       '0,       3);        // head
    queue_request(OP_DELETE,   '0,    '0,       '0,       2);        // tail
    queue_request(OP_DELETE,   '0,    '0,       '0,       4);        // already gone
    // Random part in three idling phases; wait for all outstanding results at the start of each phase.
    for (k = 0; k < RANDOM_COUNT; k++) begin
      idle = (k < RANDOM_COUNT / 3) ? 12 : (k < 2 * RANDOM_COUNT / 3) ? 74 : 0;
      r = random_request(idle);
      r.drain_first = (k == 0 || k == RANDOM_COUNT / 3 || k == 2 * RANDOM_COUNT / 3);
      request_backlog.push_back(r);
    end
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    while (request_backlog.size() != 0 || start || due_outcomes.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (due_outcomes.size() != 0 || start) log_mismatch("results missing at end of run");
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Driver: on acceptance, advance the model and queue the expected result,
  // then present the next request unless this cycle idles or a drain is due.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    request_t nxt;
    logic     free;
    int       n;
    if (rst) begin
      start <= 1'b0;
    end else begin
      free = !start;
      if (start && !busy) begin
        due_outcomes.push_back(timer_queue_step(in_flight));
        free = 1'b1;
      end
      if (free) begin
        if (request_backlog.size() != 0
            && $urandom_range(99) >= request_backlog[0].idle_pct
            && (!request_backlog[0].drain_first || due_outcomes.size() == 0)) begin
          nxt = request_backlog.pop_front();
          if (nxt.live_target) begin
            n = fill_level();
            if (n > 0) nxt.target = slots[$urandom_range(n - 1)].id;
          end
          in_flight     = nxt;
          start         <= 1'b1;
          op            <= nxt.op;
          task_handle   <= nxt.handle;
          start_delay   <= nxt.delay;
          repeat_period <= nxt.period;
          target_id     <= nxt.target;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: take each result in its done cycle and check it against the oldest
  // expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    outcome_t want;
    if (!rst && done) begin
      if (due_outcomes.size() == 0) begin
        log_mismatch($sformatf("unexpected result: id=%0h success=%0b handle=%0h",
                               result_id, success, run_handle));
      end else begin
        want = due_outcomes.pop_front();
        if (result_id !== want.rid || success !== want.ok || run_handle !== want.run)
          log_mismatch($sformatf(
            {"result mismatch: expected id=%0h success=%0b handle=%0h, ",
             "got id=%0h success=%0b handle=%0h"},
            want.rid, want.ok, want.run, result_id, success, run_handle));
      end
    end
  end

  // Bound the run in case the block hangs.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

endmodule

@@ sim.f @@
+incdir+sv
sv/dtq_pkg.sv
sv/dtq_cell.sv
sv/delta_timer_task_queue_core.sv
tb/sv/delta_timer_task_queue_core_test.sv
